>>> design/swg_pkg.sv
// Package for the spiral waypoint generator: widths, CORDIC constants,
// the arctangent table, register indexes and a clamp. No dependencies.
package swg_pkg;

    localparam int INDEX_BITS_DEF = 16;
    localparam int ANGLE_BITS_DEF = 32;
    localparam int STEPS          = 31;
    localparam int CW             = 34;
    localparam int NREG           = 6;
    localparam int REG_IDX_BITS   = 3;

    localparam logic [REG_IDX_BITS-1:0] REG_START_ARC    = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_ARC_STEP     = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_START_LAT    = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_HEADING_STEP = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_START_ALT    = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_ALT_STEP     = 3'd5;

    localparam logic signed [CW-1:0] ONE_Q30   = 34'sd1073741824;
    localparam logic signed [CW-1:0] CORDIC_K  = 34'sd652032874;

    function automatic logic [31:0] atan_entry(input int k);
        logic [31:0] t;
        case (k)
            0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
            3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
            6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
            9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
            12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
            15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
            18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
            21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
            24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
            27: t = 32'h00000005; 28: t = 32'h00000003; 29: t = 32'h00000001;
            30: t = 32'h00000001;
            default: t = 32'h0;
        endcase
        return t;
    endfunction

    function automatic logic signed [CW-1:0] clamp1(input logic signed [CW-1:0] v);
        if (v > ONE_Q30) return ONE_Q30;
        if (v < -ONE_Q30) return -ONE_Q30;
        return v;
    endfunction

endpackage

>>> design/swg_sincos.sv
// Pipelined rotation CORDIC: one step per register stage, sine and cosine
// in Q30, clamped to +-1. Depends on swg_pkg. Sideband is carried along.
module swg_sincos import swg_pkg::*; #(
    parameter int SB = 1
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [31:0]          i_angle,
    input  logic [SB-1:0]        i_sb,
    output logic signed [CW-1:0] o_sin,
    output logic signed [CW-1:0] o_cos,
    output logic [SB-1:0]        o_sb
);
    logic signed [CW-1:0] r_x [STEPS+1];
    logic signed [CW-1:0] r_y [STEPS+1];
    logic signed [32:0]   r_z [STEPS+1];
    logic                 r_f [STEPS+1];
    logic [SB-1:0]        r_s [STEPS+1];
    logic [31:0]          n_a;
    logic                 n_f;

    assign n_a = i_angle + 32'h40000000;
    assign n_f = n_a[31];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CORDIC_K;
            r_y[0] <= '0;
            r_z[0] <= 33'(signed'(n_f ? (i_angle ^ 32'h80000000) : i_angle));
            r_f[0] <= n_f;
            r_s[0] <= i_sb;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_st
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[k][32]) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - 33'(atan_entry(k));
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + 33'(atan_entry(k));
                end
                r_f[k+1] <= r_f[k];
                r_s[k+1] <= r_s[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= r_f[STEPS] ? -clamp1(r_x[STEPS]) : clamp1(r_x[STEPS]);
            o_sin <= r_f[STEPS] ? -clamp1(r_y[STEPS]) : clamp1(r_y[STEPS]);
            o_sb  <= r_s[STEPS];
        end
    end
endmodule

>>> design/swg_atan2.sv
// Pipelined vectoring CORDIC atan2 giving a 32-bit binary angle, zero for
// the origin. Depends on swg_pkg. Sideband is carried along.
module swg_atan2 import swg_pkg::*; #(
    parameter int SB = 1
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CW-1:0] i_y,
    input  logic signed [CW-1:0] i_x,
    input  logic [SB-1:0]        i_sb,
    output logic [31:0]          o_ang,
    output logic [SB-1:0]        o_sb
);
    localparam int W = CW + 2;
    logic signed [W-1:0] r_x [STEPS+1];
    logic signed [W-1:0] r_y [STEPS+1];
    logic [31:0]         r_z [STEPS+1];
    logic                r_o [STEPS+1];
    logic [SB-1:0]       r_s [STEPS+1];
    logic signed [W-1:0] n_x, n_y;

    assign n_x = W'(i_x);
    assign n_y = W'(i_y);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= n_x[W-1] ? -n_x : n_x;
            r_y[0] <= n_x[W-1] ? -n_y : n_y;
            r_z[0] <= n_x[W-1] ? 32'h80000000 : 32'h0;
            r_o[0] <= (i_x == '0) && (i_y == '0);
            r_s[0] <= i_sb;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_st
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_y[k][W-1]) begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + atan_entry(k);
                end else begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - atan_entry(k);
                end
                r_o[k+1] <= r_o[k];
                r_s[k+1] <= r_s[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ang <= r_o[STEPS] ? 32'h0 : r_z[STEPS];
            o_sb  <= r_s[STEPS];
        end
    end
endmodule

>>> design/swg_isqrt.sv
// Pipelined restoring square root of a 62-bit value, one result bit per
// stage. No package use beyond widths from the caller. Sideband carried.
module swg_isqrt #(
    parameter int SB = 1
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [61:0]   i_n,
    input  logic [SB-1:0] i_sb,
    output logic [31:0]   o_root,
    output logic [SB-1:0] o_sb
);
    localparam int NB = 31;
    logic [61:0]   r_n [NB+1];
    logic [31:0]   r_q [NB+1];
    logic [33:0]   r_r [NB+1];
    logic [SB-1:0] r_s [NB+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0] <= i_n;
            r_q[0] <= '0;
            r_r[0] <= '0;
            r_s[0] <= i_sb;
        end
    end

    for (genvar k = 0; k < NB; k++) begin : g_st
        logic [33:0] w_t;
        logic [33:0] w_d;
        assign w_t = {r_r[k][31:0], r_n[k][61:60]};
        assign w_d = {r_q[k], 2'b01};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[k+1] <= {r_n[k][59:0], 2'b00};
                if (w_t >= w_d) begin
                    r_r[k+1] <= w_t - w_d;
                    r_q[k+1] <= {r_q[k][30:0], 1'b1};
                end else begin
                    r_r[k+1] <= w_t;
                    r_q[k+1] <= {r_q[k][30:0], 1'b0};
                end
                r_s[k+1] <= r_s[k];
            end
        end
    end

    assign o_root = r_q[NB];
    assign o_sb   = r_s[NB];
endmodule

>>> design/spiral_waypoint_generator.sv
// Top level of the spiral waypoint generator: configuration registers,
// angle set-up, trig combination, altitude ramp. Uses swg_pkg and submodules.
//
// The block takes one point index per cycle, when not stalled, and returns one
// waypoint per index, in order. It is a single flow-through pipeline of 104
// register stages: two set-up stages, 33 for the sine/cosine CORDICs, four
// for the products, 32 for the square root and 33 for the two atan2 CORDICs.
// Throughput is one transfer per cycle while the output is not stalled. The
// whole pipeline advances only when its last stage is empty or its result is
// being taken, so a stall holds every item in place and nothing is lost.
// Configuration must be written while idle.
module spiral_waypoint_generator import swg_pkg::*; #(
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [INDEX_BITS-1:0]   i_point_index,
    input  logic                    i_last_in,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [31:0]      o_lat_out,
    output logic signed [31:0]      o_lon_out,
    output logic signed [31:0]      o_alt_out,
    output logic                    o_last_out,
    input  logic                    i_cfg_we,
    input  logic [REG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [31:0]             i_cfg_data
);
    localparam logic [31:0] QMASK = 32'hFFFFFFFF << (32 - ANGLE_BITS);
    // Sideband through the trig path: the saturated altitude and last flag.
    localparam int SB = 33;
    // Full width of a Q30 by Q30 product.
    localparam int PW = 2 * CW;

    logic [31:0] r_cfg [NREG];
    logic        w_en;

    // Global pipeline enable: advance unless the output holds a stalled item.
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NREG; k++) r_cfg[k] <= '0;
        end else if (i_cfg_we && (int'(i_cfg_idx) < NREG)) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    // Stage A: index products (index times register; arc and heading truncated to 32 bits).
    logic [31:0]        r_d, r_h;
    logic signed [63:0] r_altw;
    logic               r_la;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d    <= r_cfg[REG_START_ARC] + 32'(r_cfg[REG_ARC_STEP] * 32'(i_point_index));
            r_h    <= 32'(r_cfg[REG_HEADING_STEP] * 32'(i_point_index));
            r_altw <= 64'(signed'(r_cfg[REG_START_ALT]))
                    + signed'(64'(i_point_index)) * 64'(signed'(r_cfg[REG_ALT_STEP]));
            r_la   <= i_last_in;
        end
    end

    // Stage B: quantize angles and saturate altitude.
    logic [31:0] r_dq, r_hq;
    logic [SB-1:0] r_sbB;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dq <= r_d & QMASK;
            r_hq <= r_h & QMASK;
            if (r_altw > 64'sd2147483647)       r_sbB <= {r_la, 32'h7FFFFFFF};
            else if (r_altw < -64'sd2147483648) r_sbB <= {r_la, 32'h80000000};
            else                                r_sbB <= {r_la, r_altw[31:0]};
        end
    end

    // Three CORDICs in lockstep; the start latitude is a constant angle.
    logic signed [CW-1:0] w_sd, w_cd, w_sh, w_ch, w_sb, w_cb;
    logic [SB-1:0]        w_sb1;
    logic                 w_u1, w_u2;
    swg_sincos #(.SB(SB)) u_d (.i_clk, .i_en(w_en), .i_angle(r_dq),
        .i_sb(r_sbB), .o_sin(w_sd), .o_cos(w_cd), .o_sb(w_sb1));
    swg_sincos #(.SB(1)) u_h (.i_clk, .i_en(w_en), .i_angle(r_hq),
        .i_sb(1'b0), .o_sin(w_sh), .o_cos(w_ch), .o_sb(w_u1));
    swg_sincos #(.SB(1)) u_b (.i_clk, .i_en(w_en),
        .i_angle(r_cfg[REG_START_LAT] & QMASK), .i_sb(1'b0),
        .o_sin(w_sb), .o_cos(w_cb), .o_sb(w_u2));

    // Products, each registered; the operands are widened to the full
    // product width and the shifts floor.
    logic signed [CW-1:0] r_p1, r_p2, r_p3, r_cd1, r_ch1, r_sb1, r_cb1, r_sd1;
    logic [SB-1:0]        r_sbC;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1  <= CW'((PW'(w_sb) * PW'(w_cd)) >>> 30);
            r_p2  <= CW'((PW'(w_cb) * PW'(w_sd)) >>> 30);
            r_p3  <= CW'((PW'(w_sh) * PW'(w_sd)) >>> 30);
            r_cd1 <= w_cd; r_ch1 <= w_ch; r_sb1 <= w_sb; r_cb1 <= w_cb;
            r_sd1 <= w_sd;
            r_sbC <= w_sb1;
        end
    end

    logic signed [CW-1:0] r_q2, r_q3, r_p1b, r_cd2, r_sb2;
    logic [SB-1:0]        r_sbD;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_q2  <= CW'((PW'(r_p2) * PW'(r_ch1)) >>> 30);
            r_q3  <= CW'((PW'(r_p3) * PW'(r_cb1)) >>> 30);
            r_p1b <= r_p1; r_cd2 <= r_cd1; r_sb2 <= r_sb1;
            r_sbD <= r_sbC;
        end
    end

    logic signed [CW-1:0] r_v, r_q3b, r_cd3, r_sb3;
    logic [SB-1:0]        r_sbE;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_v   <= clamp1(r_p1b + r_q2);
            r_q3b <= r_q3; r_cd3 <= r_cd2; r_sb3 <= r_sb2;
            r_sbE <= r_sbD;
        end
    end

    logic [61:0]          r_rad;
    logic signed [CW-1:0] r_v2, r_ly, r_lx;
    logic [SB-1:0]        r_sbF;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rad <= 62'(64'sh1000000000000000 - 64'(r_v) * 64'(r_v));
            r_v2  <= r_v;
            r_ly  <= r_q3b;
            r_lx  <= r_cd3 - CW'((PW'(r_sb3) * PW'(r_v)) >>> 30);
            r_sbF <= r_sbE;
        end
    end

    // Square root with the altitude and last flag, v and the longitude operands as sideband.
    localparam int SQB = SB + 3 * CW;
    logic [31:0]    w_root;
    logic [SQB-1:0] w_sqs;
    swg_isqrt #(.SB(SQB)) u_sq (.i_clk, .i_en(w_en), .i_n(r_rad),
        .i_sb({r_sbF, r_v2, r_ly, r_lx}), .o_root(w_root), .o_sb(w_sqs));

    logic [31:0]   w_lat, w_lon;
    logic [SB-1:0] w_sbo;
    logic          w_u3;
    swg_atan2 #(.SB(SB)) u_lat (.i_clk, .i_en(w_en),
        .i_y(w_sqs[3*CW-1:2*CW]), .i_x(CW'({2'b00, w_root})),
        .i_sb(w_sqs[SQB-1:3*CW]), .o_ang(w_lat), .o_sb(w_sbo));
    swg_atan2 #(.SB(1)) u_lon (.i_clk, .i_en(w_en),
        .i_y(w_sqs[2*CW-1:CW]), .i_x(w_sqs[CW-1:0]), .i_sb(1'b0),
        .o_ang(w_lon), .o_sb(w_u3));

    // Valid shift line matching the data depth: set-up, sine/cosine,
    // products, square root (input stage plus 31 bit stages), atan2.
    localparam int DEPTH = 2 + (STEPS + 2) + 4 + 32 + (STEPS + 2);
    logic [DEPTH-1:0] r_vl;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vl <= '0;
        else if (w_en) r_vl <= {r_vl[DEPTH-2:0], i_valid};
    end

    logic signed [CW-1:0] w_latc;
    assign w_latc = clamp1(CW'(signed'(w_lat)));
    assign o_valid    = r_vl[DEPTH-1];
    assign o_lat_out  = w_latc[31:0];
    assign o_lon_out  = w_lon;
    assign o_alt_out  = w_sbo[31:0];
    assign o_last_out = w_sbo[32] ^ (w_u1 & w_u2 & w_u3 & 1'b0);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_alt_out) && $stable(o_lat_out)))
        else $error("stalled result changed");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not follow output stall");
endmodule

>>> test/spiral_waypoint_generator_tb.sv
// Self-checking testbench for the spiral waypoint generator: drives point
// indices and register writes, predicts each waypoint in fixed point and
// compares it with the block's output. Depends on swg_pkg and the RTL top.
module spiral_waypoint_generator_tb;
    import swg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY  = 200;
    localparam int WDOG_MAX = 20000;
    localparam int N_RAND   = 950;

    // Register indexes past the last register; writes to them are ignored.
    localparam logic [REG_IDX_BITS-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [REG_IDX_BITS-1:0] REG_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic signed [31:0] lat;
        logic signed [31:0] lon;
        logic signed [31:0] alt;
        logic               last;
    } waypoint_t;

    // The expected-waypoint store also owns its copy of the registers, so that
    // each accepted index is turned into a waypoint the moment it is taken.
    class waypoint_board;
        logic [31:0] regs [NREG];
        waypoint_t   pending [$];
        int          errors;
        int          checked;

        function void clear_regs();
            foreach (regs[k]) regs[k] = '0;
        endfunction

        function automatic longint clampq(longint v);
            if (v > 64'sd1073741824) return 64'sd1073741824;
            if (v < -64'sd1073741824) return -64'sd1073741824;
            return v;
        endfunction

        function automatic longint mulq(longint a, longint b);
            return (a * b) >>> 30;
        endfunction

        // Rotation CORDIC; the half of the circle around pi is folded first.
        function automatic void trig(logic [31:0] a, output longint s, output longint c);
            logic   flip;
            longint x, y, z, xs, ys;
            logic [31:0] t;
            t = a + 32'h40000000;
            flip = t[31];
            if (flip) a = a ^ 32'h80000000;
            x = 652032874; y = 0; z = longint'($signed(a));
            for (int k = 0; k < STEPS; k++) begin
                xs = x >>> k; ys = y >>> k;
                if (z >= 0) begin
                    x -= ys; y += xs; z -= longint'(atan_entry(k));
                end else begin
                    x += ys; y -= xs; z += longint'(atan_entry(k));
                end
            end
            x = clampq(x); y = clampq(y);
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function automatic longint bearing(longint y, longint x);
            logic [31:0] z;
            longint xs, ys;
            if (x == 0 && y == 0) return 0;
            z = '0;
            if (x < 0) begin
                x = -x; y = -y; z = 32'h80000000;
            end
            for (int k = 0; k < STEPS; k++) begin
                xs = x >>> k; ys = y >>> k;
                if (y >= 0) begin
                    x += ys; y -= xs; z += atan_entry(k);
                end else begin
                    x -= ys; y += xs; z -= atan_entry(k);
                end
            end
            return longint'($signed(z));
        endfunction

        function automatic longint root(logic [63:0] n);
            logic [63:0] r, b;
            r = 0; b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n -= r + b; r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return longint'(r);
        endfunction

        function void note_index(logic [15:0] idx, logic last);
            logic [31:0] d, h;
            longint sd, cd, sh, ch, sb, cb, v, r, la, lo, al;
            waypoint_t w;
            d = regs[REG_START_ARC] + 32'(idx) * regs[REG_ARC_STEP];
            h = 32'(idx) * regs[REG_HEADING_STEP];
            trig(d, sd, cd);
            trig(h, sh, ch);
            trig(regs[REG_START_LAT], sb, cb);
            v  = clampq(mulq(sb, cd) + mulq(mulq(cb, sd), ch));
            r  = root(64'(64'sd1152921504606846976 - v * v));
            la = clampq(bearing(v, r));
            lo = bearing(mulq(mulq(sh, sd), cb), cd - mulq(sb, v));
            al = longint'($signed(regs[REG_START_ALT]))
                 + longint'(idx) * longint'($signed(regs[REG_ALT_STEP]));
            if (al > 64'sd2147483647) al = 64'sd2147483647;
            if (al < -64'sd2147483648) al = -64'sd2147483648;
            w.lat = la[31:0]; w.lon = lo[31:0]; w.alt = al[31:0]; w.last = last;
            pending = {pending, w};
        endfunction

        task check_waypoint(waypoint_t got);
            waypoint_t want;
            checked++;
            if (pending.size() == 0) begin
                report_mismatch("unexpected waypoint", 0, 0);
                return;
            end
            want = pending.pop_front();
            if (got.lat !== want.lat) report_mismatch("lat_out", got.lat, want.lat);
            if (got.lon !== want.lon) report_mismatch("lon_out", got.lon, want.lon);
            if (got.alt !== want.alt) report_mismatch("alt_out", got.alt, want.alt);
            if (got.last !== want.last) report_mismatch("last_out", got.last, want.last);
        endtask

        task report_mismatch(string what, longint got, longint want);
            errors++;
            $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [15:0] i_point_index = '0;
    logic        i_last_in = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic signed [31:0] o_lat_out, o_lon_out, o_alt_out;
    logic        o_last_out;
    logic        i_cfg_we = 1'b0;
    logic [REG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    waypoint_board board = new();
    int idle_pct  = 0;   // chance in a hundred that the sender idles
    int stall_pct = 0;   // chance in a hundred that the receiver stalls
    int quiet_cycles = 0;
    int sent = 0;

    always #10 i_clk = ~i_clk;

    spiral_waypoint_generator dut (.*);

    // Output side: sample at the rising edge, update stall at the falling one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_waypoint('{o_lat_out, o_lon_out, o_alt_out, o_last_out});
    end
    always @(negedge i_clk)
        i_stall <= ($urandom_range(99) < stall_pct);

    // Watchdog: counts cycles without any transfer on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [REG_IDX_BITS-1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= data;
        if (idx < NREG) board.regs[idx] = data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Sends one index; valid stays high back to back unless the sender idles.
    task automatic send_index(logic [15:0] idx, logic last);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1; i_point_index <= idx; i_last_in <= last;
        do @(posedge i_clk); while (o_stall);
        board.note_index(idx, last);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    task automatic load_all(logic [31:0] arc0, logic [31:0] arcs, logic [31:0] lat,
                            logic [31:0] hs, logic [31:0] alt0, logic [31:0] alts);
        write_reg(REG_START_ARC, arc0);
        write_reg(REG_ARC_STEP, arcs);
        write_reg(REG_START_LAT, lat);
        write_reg(REG_HEADING_STEP, hs);
        write_reg(REG_START_ALT, alt0);
        write_reg(REG_ALT_STEP, alts);
    endtask

    // A run of consecutive indices, as the host sends them, ending with last.
    task automatic send_run(int len);
        int base;
        base = $urandom_range(65535);
        for (int k = 0; k < len; k++)
            send_index(16'(base + k), k == len - 1);
    endtask

    initial begin
        board.clear_regs();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: reset registers, then index and field extremes and
        // register extremes.
        send_index(16'h0000, 1'b0);
        send_index(16'hFFFF, 1'b1);
        drain();
        load_all(32'h40000000, 32'h00010000, 32'h40000000, 32'h01000000,
                 32'h7FFF0000, 32'h7FFFFFFF);
        send_index(16'h0000, 1'b0);
        send_index(16'h0001, 1'b0);
        send_index(16'hFFFF, 1'b1);
        drain();
        load_all(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hC0000000, 32'hFFFFFFFF,
                 32'h80000000, 32'h80000000);
        send_index(16'h0000, 1'b0);
        send_index(16'h5555, 1'b0);
        send_index(16'hAAAA, 1'b0);
        send_index(16'hFFFF, 1'b1);
        drain();
        // Latitude beyond a quarter turn, a full half turn of arc, and
        // writes to two indexes past the last register that must be ignored.
        load_all(32'h80000000, 32'h00000000, 32'h7FFFFFFF, 32'h80000000,
                 32'h00000000, 32'h00000001);
        write_reg(REG_UNUSED_HI, 32'hDEADBEEF);
        write_reg(REG_UNUSED_LO, 32'h12345678);
        send_index(16'h0001, 1'b0);
        send_index(16'h0002, 1'b1);
        drain();

        // Random phases cycle through the idling profiles.
        for (int ph = 0; ph < 10; ph++) begin
            case (ph % 5)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 85; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 85; end
                3: begin idle_pct = 20; stall_pct = 20; end
                default: begin idle_pct = $urandom_range(50); stall_pct = $urandom_range(50); end
            endcase
            load_all($urandom, $urandom, 32'($signed($urandom_range(32'h80000000)) - 32'sh40000000),
                     $urandom, $urandom, (ph % 3 == 0) ? 32'h0 : $urandom);
            while (sent < 23 + (ph + 1) * N_RAND / 10) begin
                if ($urandom_range(9) < 8) send_run($urandom_range(1, 12));
                else send_index(16'($urandom), 1'($urandom));
            end
            drain();
        end
        idle_pct = 0; stall_pct = 0;

        $display("Sent %0d indices over 14 register settings; %0d waypoints checked.",
                 sent, board.checked);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
